@@ src/ic72_pkg.sv @@
// Shared types and constants for the 72-source interrupt controller.
// No dependencies; imported by ic72_lowbit and interrupt_controller_72_source.
`default_nettype none

package ic72_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        KIND_LEVEL  = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_READ   = 2'd2,
        KIND_VECTOR = 2'd3
    } kind_t;

    // Register indexes
    localparam logic [3:0] REG_BASIC_PEND = 4'd0;
    localparam logic [3:0] REG_PEND1      = 4'd1;
    localparam logic [3:0] REG_PEND2      = 4'd2;
    localparam logic [3:0] REG_FIQ        = 4'd3;
    localparam logic [3:0] REG_ENABLE1    = 4'd4;
    localparam logic [3:0] REG_ENABLE2    = 4'd5;
    localparam logic [3:0] REG_ENABLE_BAS = 4'd6;
    localparam logic [3:0] REG_DISABLE1   = 4'd7;
    localparam logic [3:0] REG_DISABLE2   = 4'd8;
    localparam logic [3:0] REG_DISABLE_BAS = 4'd9;

    localparam int unsigned NUM_SOURCES = 72;
    localparam int unsigned SRC_W       = 7;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BASIC_W     = 8;
    localparam int unsigned BIT_IDX_W   = 5;

    // Vector number offsets of the three groups
    localparam logic [SRC_W-1:0] BASE_PEND1 = 7'd0;
    localparam logic [SRC_W-1:0] BASE_PEND2 = 7'd32;
    localparam logic [SRC_W-1:0] BASE_BASIC = 7'd64;

endpackage

`default_nettype wire

@@ src/interrupt_controller_72_source.sv @@
// Top level of the 72-source interrupt controller: input stage, state, result stage.
// Depends on ic72_pkg and ic72_lowbit.
//
//  channel  | dir | tdata (low bit up)                                | tuser
//  s_axis   | in  | source_index[6:0] source_level[7] register_index  | kind[1:0]
//           |     | [11:8] write_data[43:12], zero[47:44]             |
//  m_axis   | out | read_data[31:0] vector_number[38:32] zero[39]     | vector_valid
//
// One item is taken per cycle while the output is not stalled; each item yields one result,
// held first in an input register, then through the mask/priority logic in a result register.
// Source levels and enables update in item order, so a read sees every earlier item.
// Reset clears the levels, the enable mask and both stage valid flags.
// A stalled output holds its result while the input register keeps one more item.
`default_nettype none

module interrupt_controller_72_source
    import ic72_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // source_index, source_level, register_index,
                                             // write_data, zero pad
    input  wire logic [1:0]  s_axis_tuser,   // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,   // read_data, vector_number, zero pad
    output logic             m_axis_tuser    // vector_valid
);

    // Input stage
    logic                in_valid_reg, in_valid_next;
    logic [1:0]          in_kind_reg;
    logic [SRC_W-1:0]    in_src_reg;
    logic                in_lvl_reg;
    logic [3:0]          in_regidx_reg;
    logic [WORD_W-1:0]   in_data_reg;

    // State
    logic [NUM_SOURCES-1:0] levels_reg, levels_next;
    logic [NUM_SOURCES-1:0] enable_reg, enable_next;

    // Result stage
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   rd_reg, rd_next;
    logic [SRC_W-1:0]    vnum_reg, vnum_next;
    logic                vvalid_reg, vvalid_next;

    logic                in_xfer;
    logic                advance;
    kind_t               kind;

    logic [WORD_W-1:0]   pend1;
    logic [WORD_W-1:0]   pend2;
    logic [BASIC_W-1:0]  pend_basic;
    logic [WORD_W-1:0]   basic_word;
    logic [WORD_W-1:0]   pick_word;
    logic [SRC_W-1:0]    pick_base;
    logic                pick_any;
    logic [BIT_IDX_W-1:0] pick_idx;

    // Handshake: the input register frees up whenever its item moves on
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign kind          = kind_t'(in_kind_reg);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Capture an input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_kind_reg   <= s_axis_tuser;
            in_src_reg    <= s_axis_tdata[6:0];
            in_lvl_reg    <= s_axis_tdata[7];
            in_regidx_reg <= s_axis_tdata[11:8];
            in_data_reg   <= s_axis_tdata[43:12];
        end
    end

    // Pending words and basic pending summary
    assign pend1      = levels_reg[31:0] & enable_reg[31:0];
    assign pend2      = levels_reg[63:32] & enable_reg[63:32];
    assign pend_basic = levels_reg[71:64] & enable_reg[71:64];
    assign basic_word = {22'd0, |pend2, |pend1, pend_basic};

    // Choose the group for a vector query: basic, then pending1, then pending2
    always_comb
    begin
        pick_any  = 1'b1;
        pick_word = pend2;
        pick_base = BASE_PEND2;
        if (|pend_basic)
        begin
            pick_word = {24'd0, pend_basic};
            pick_base = BASE_BASIC;
        end
        else if (|pend1)
        begin
            pick_word = pend1;
            pick_base = BASE_PEND1;
        end
        else if (!(|pend2))
        begin
            pick_any = 1'b0;
        end
    end

    ic72_lowbit u_lowbit
    (
        .word  (pick_word),
        .index (pick_idx)
    );

    // Process the held item: update state and form its result
    always_comb
    begin
        levels_next    = levels_reg;
        enable_next    = enable_reg;
        out_valid_next = out_valid_reg;
        rd_next        = rd_reg;
        vnum_next      = vnum_reg;
        vvalid_next    = vvalid_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
            rd_next        = '0;
            vnum_next      = '0;
            vvalid_next    = 1'b0;
            unique case (kind)
                KIND_LEVEL:
                begin
                    if (in_src_reg < SRC_W'(NUM_SOURCES))
                    begin
                        levels_next[in_src_reg] = in_lvl_reg;
                    end
                end
                KIND_WRITE:
                begin
                    unique case (in_regidx_reg)
                        REG_ENABLE1:     enable_next[31:0]  = enable_reg[31:0] | in_data_reg;
                        REG_ENABLE2:     enable_next[63:32] = enable_reg[63:32] | in_data_reg;
                        REG_ENABLE_BAS:  enable_next[71:64] = enable_reg[71:64]
                                                              | in_data_reg[7:0];
                        REG_DISABLE1:    enable_next[31:0]  = enable_reg[31:0] & ~in_data_reg;
                        REG_DISABLE2:    enable_next[63:32] = enable_reg[63:32] & ~in_data_reg;
                        REG_DISABLE_BAS: enable_next[71:64] = enable_reg[71:64]
                                                              & ~in_data_reg[7:0];
                        default:         enable_next = enable_reg;
                    endcase
                end
                KIND_READ:
                begin
                    unique case (in_regidx_reg)
                        REG_BASIC_PEND:                    rd_next = basic_word;
                        REG_PEND1:                         rd_next = pend1;
                        REG_PEND2:                         rd_next = pend2;
                        REG_ENABLE1, REG_DISABLE1:         rd_next = enable_reg[31:0];
                        REG_ENABLE2, REG_DISABLE2:         rd_next = enable_reg[63:32];
                        REG_ENABLE_BAS, REG_DISABLE_BAS:   rd_next = {24'd0, enable_reg[71:64]};
                        default:                           rd_next = '0;
                    endcase
                end
                KIND_VECTOR:
                begin
                    if (pick_any)
                    begin
                        vnum_next   = pick_base + {2'd0, pick_idx};
                        vvalid_next = 1'b1;
                    end
                end
                default:
                begin
                    rd_next = '0;
                end
            endcase
        end
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg    <= '0;
            enable_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            levels_reg    <= levels_next;
            enable_reg    <= enable_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg     <= rd_next;
        vnum_reg   <= vnum_next;
        vvalid_reg <= vvalid_next;
    end

    // Drive the output channel
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, vnum_reg, rd_reg};
    assign m_axis_tuser  = vvalid_reg;

    // A found vector always names a real source
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && vvalid_reg) |-> (vnum_reg < SRC_W'(NUM_SOURCES)))
        else $error("vector number beyond the last source");

    // Without a found vector the number reads zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !vvalid_reg) |-> (vnum_reg == '0))
        else $error("vector number set without a pending source");

    // Only a query returns a vector, and a query returns no read data
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && vvalid_reg) |-> (rd_reg == '0))
        else $error("read data set on a vector result");

    // A held item that cannot move on stays in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input item dropped while the output stalled");

    // Source levels and enables only change when an item is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(levels_reg) && $stable(enable_reg))
        else $error("state changed without a processed item");

endmodule

`default_nettype wire

@@ src/ic72_lowbit.sv @@
// Lowest-set-bit encoder over one 32-bit pending word.
// Depends on ic72_pkg for widths.
`default_nettype none

module ic72_lowbit
    import ic72_pkg::*;
(
    input  wire logic [WORD_W-1:0]    word,
    output logic      [BIT_IDX_W-1:0] index
);

    logic [WORD_W-1:0] lowest;

    // Isolate the lowest one, then OR its position bits together
    always_comb
    begin
        lowest = word & (~word + WORD_W'(1));
        index  = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (lowest[i])
            begin
                index = index | BIT_IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ bench/tb_interrupt_controller_72_source.sv @@
// Self-checking bench for the 72-source interrupt controller: a directed table, then random traffic in
// three idle phases, every result checked against a local predictor or a typed row's fixed reply.
// Depends on ic72_pkg and interrupt_controller_72_source.
`timescale 1ns / 1ps

module tb_interrupt_controller_72_source;
    import ic72_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1550;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        kind_t      kind;
        logic [6:0] src;
        logic       lvl;
        logic [3:0] regi;
        logic [31:0] data;
    } bus_item_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic [6:0]  vnum;
        logic        vvalid;
    } bus_reply_t;

    typedef struct packed {
        bus_item_t  item;
        logic       typed;
        bus_reply_t reply;
    } table_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [47:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [39:0] m_data;
    logic        m_user;

    // Predictor state: source line levels and the enable mask
    logic [71:0] line_levels = '0;
    logic [71:0] enable_bits = '0;

    bus_reply_t replies_due[$];
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         fail_count = 0;
    int         cycle_count = 0;

    interrupt_controller_72_source u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    always #5 clk = ~clk;

    function automatic logic [6:0] lowest_set(input logic [31:0] v);
        logic [6:0] n;
        n = '0;
        for (int b = 31; b >= 0; b--)
            if (v[b])
                n = 7'(b);
        return n;
    endfunction

    // Apply one item to the controller state and return the reply it produces
    function automatic bus_reply_t apply_to_controller(input bus_item_t it);
        bus_reply_t  rep;
        logic [71:0] pend;
        rep  = '0;
        pend = line_levels & enable_bits;
        case (it.kind)
            KIND_LEVEL:
                if (it.src < NUM_SOURCES)
                    line_levels[it.src] = it.lvl;
            KIND_WRITE:
                case (it.regi)
                    REG_ENABLE1:     enable_bits[31:0]  = enable_bits[31:0] | it.data;
                    REG_ENABLE2:     enable_bits[63:32] = enable_bits[63:32] | it.data;
                    REG_ENABLE_BAS:  enable_bits[71:64] = enable_bits[71:64] | it.data[7:0];
                    REG_DISABLE1:    enable_bits[31:0]  = enable_bits[31:0] & ~it.data;
                    REG_DISABLE2:    enable_bits[63:32] = enable_bits[63:32] & ~it.data;
                    REG_DISABLE_BAS: enable_bits[71:64] = enable_bits[71:64] & ~it.data[7:0];
                    default: ;
                endcase
            KIND_READ:
                case (it.regi)
                    REG_BASIC_PEND:
                        rep.rdata = {22'd0, |pend[63:32], |pend[31:0], pend[71:64]};
                    REG_PEND1:       rep.rdata = pend[31:0];
                    REG_PEND2:       rep.rdata = pend[63:32];
                    REG_ENABLE1,
                    REG_DISABLE1:    rep.rdata = enable_bits[31:0];
                    REG_ENABLE2,
                    REG_DISABLE2:    rep.rdata = enable_bits[63:32];
                    REG_ENABLE_BAS,
                    REG_DISABLE_BAS: rep.rdata = {24'd0, enable_bits[71:64]};
                    default:         rep.rdata = '0;
                endcase
            default:
                // Group order: basic sources, then pending1, then pending2
                if (|pend[71:64]) begin
                    rep.vnum   = BASE_BASIC + lowest_set({24'd0, pend[71:64]});
                    rep.vvalid = 1'b1;
                end
                else if (|pend[31:0]) begin
                    rep.vnum   = BASE_PEND1 + lowest_set(pend[31:0]);
                    rep.vvalid = 1'b1;
                end
                else if (|pend[63:32]) begin
                    rep.vnum   = BASE_PEND2 + lowest_set(pend[63:32]);
                    rep.vvalid = 1'b1;
                end
        endcase
        return rep;
    endfunction

    function automatic table_row_t stim(input kind_t k, input logic [6:0] s, input logic l,
                                        input logic [3:0] r, input logic [31:0] d,
                                        input logic t, input logic [31:0] rd,
                                        input logic [6:0] vn, input logic vv);
        table_row_t row;
        row.item  = '{kind: k, src: s, lvl: l, regi: r, data: d};
        row.typed = t;
        row.reply = '{rdata: rd, vnum: vn, vvalid: vv};
        return row;
    endfunction

    // Random traffic: mostly level changes and enable/disable writes, with noise
    function automatic bus_item_t random_item();
        bus_item_t it;
        int        sel;
        it.kind = kind_t'($urandom_range(0, 3));
        it.src  = 7'($urandom_range(0, 127));
        it.lvl  = 1'($urandom_range(0, 1));
        it.regi = 4'($urandom_range(0, 15));
        it.data = $urandom();
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            it.kind = KIND_LEVEL;
            it.src  = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(72, 127))
                                                  : 7'($urandom_range(0, 71));
            it.lvl  = ($urandom_range(0, 99) < 60);
        end
        else if (sel < 60) begin
            it.kind = KIND_WRITE;
            if ($urandom_range(0, 7) != 0)
                it.regi = 4'($urandom_range(4, 9));
            case ($urandom_range(0, 3))
                0: it.data = $urandom();
                1: it.data = 32'd1 << $urandom_range(0, 31);
                2: it.data = '1;
                default: it.data = $urandom() & $urandom();
            endcase
        end
        else if (sel < 80)
            it.kind = KIND_READ;
        else
            it.kind = KIND_VECTOR;
        return it;
    endfunction

    // Offer one item from a falling edge; return at the falling edge after its transfer
    task automatic send_item(input bus_item_t it, input logic typed, input bus_reply_t fixed);
        bus_reply_t rep;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {4'd0, it.data, it.regi, it.lvl, it.src};
        s_user  <= it.kind;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        rep = apply_to_controller(it);
        replies_due.push_back(typed ? fixed : rep);
        @(negedge clk);
    endtask

    // Receiver stalls
    always @(negedge clk)
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Compare each transfer out with the oldest prediction
    always @(posedge clk) begin
        bus_reply_t want;
        if (m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: rd=%h vn=%0d vv=%b",
                             m_data[31:0], m_data[38:32], m_user);
            end
            else begin
                want = replies_due.pop_front();
                if (m_data[31:0] !== want.rdata || m_data[38:32] !== want.vnum ||
                    m_user !== want.vvalid) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: expected rd=%h vn=%0d vv=%b, got rd=%h vn=%0d vv=%b",
                                 want.rdata, want.vnum, want.vvalid,
                                 m_data[31:0], m_data[38:32], m_user);
                end
            end
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_interrupt_controller_72_source NOT OK");
            $finish;
        end
    end

    initial begin
        table_row_t rows[$];

        // After reset, all-ones enables, range edges, group priority, ignored accesses
        rows.push_back(stim(KIND_READ,   7'd0,   1'b0, REG_BASIC_PEND,  32'h0,
                            1'b1, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_VECTOR, 7'd0,   1'b0, REG_BASIC_PEND,  32'h0,
                            1'b1, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_READ,   7'd0,   1'b0, REG_ENABLE1,     32'h0,
                            1'b1, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_WRITE,  7'd0,   1'b0, REG_ENABLE1,     32'hFFFF_FFFF,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_WRITE,  7'd0,   1'b0, REG_ENABLE2,     32'hFFFF_FFFF,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_WRITE,  7'd0,   1'b0, REG_ENABLE_BAS,  32'hFFFF_FFFF,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_READ,   7'd0,   1'b0, REG_ENABLE_BAS,  32'h0,
                            1'b1, 32'hFF, 7'd0, 1'b0));
        rows.push_back(stim(KIND_LEVEL,  7'd0,   1'b1, REG_BASIC_PEND,  32'h0,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_LEVEL,  7'd71,  1'b1, REG_BASIC_PEND,  32'h0,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_LEVEL,  7'd127, 1'b1, REG_BASIC_PEND,  32'h0,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_LEVEL,  7'd72,  1'b1, REG_BASIC_PEND,  32'h0,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_READ,   7'd0,   1'b0, REG_BASIC_PEND,  32'h0,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_VECTOR, 7'd0,   1'b0, REG_BASIC_PEND,  32'h0,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_LEVEL,  7'd71,  1'b0, REG_BASIC_PEND,  32'h0,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_LEVEL,  7'd63,  1'b1, REG_BASIC_PEND,  32'h0,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_READ,   7'd0,   1'b0, REG_PEND1,       32'h0,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_READ,   7'd0,   1'b0, REG_PEND2,       32'h0,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_WRITE,  7'd0,   1'b0, REG_FIQ,         32'hFFFF_FFFF,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_READ,   7'd0,   1'b0, REG_FIQ,         32'h0,
                            1'b1, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_WRITE,  7'd0,   1'b0, 4'd15,           32'hFFFF_FFFF,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_READ,   7'd0,   1'b0, 4'd15,           32'h0,
                            1'b1, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_WRITE,  7'd0,   1'b0, REG_DISABLE1,    32'hFFFF_FFFF,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_LEVEL,  7'd64,  1'b1, REG_BASIC_PEND,  32'h0,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_VECTOR, 7'd0,   1'b0, REG_BASIC_PEND,  32'h0,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_WRITE,  7'd0,   1'b0, REG_DISABLE_BAS, 32'hFFFF_FF00,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_READ,   7'd0,   1'b0, REG_DISABLE_BAS, 32'h0,
                            1'b1, 32'hFF, 7'd0, 1'b0));
        rows.push_back(stim(KIND_WRITE,  7'd0,   1'b0, REG_DISABLE2,    32'hFFFF_FFFF,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_LEVEL,  7'd64,  1'b0, REG_BASIC_PEND,  32'h0,
                            1'b0, 32'h0, 7'd0, 1'b0));
        rows.push_back(stim(KIND_VECTOR, 7'd0,   1'b0, REG_BASIC_PEND,  32'h0,
                            1'b1, 32'h0, 7'd0, 1'b0));

        // Hold reset, then release on a falling edge
        send_idle_pct = 21;
        recv_idle_pct = 58;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_item(rows[i].item, rows[i].typed, rows[i].reply);

        // Three idle phases: sender light / receiver heavy, swapped, then none
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 58 : 0;
            recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 21 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
                send_item(random_item(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        // Drain, then allow the pipeline to settle
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && replies_due.size() == 0)
            $display("tb_interrupt_controller_72_source OK");
        else
            $display("tb_interrupt_controller_72_source NOT OK");
        $finish;
    end

endmodule

@@ interrupt_controller_72_source.f @@
src/ic72_pkg.sv
src/ic72_lowbit.sv
src/interrupt_controller_72_source.sv
bench/tb_interrupt_controller_72_source.sv
